### rtl/icon_record_stream_parser_defines.svh
// Assertion macros shared by the checker.
`ifndef ICON_RECORD_STREAM_PARSER_DEFINES_SVH
`define ICON_RECORD_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, masked while in reset.
`define IRSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irsp check failed");

// Next-cycle implication, masked while in reset.
`define IRSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irsp check failed");

// Next-cycle implication that is live during reset too.
`define IRSP_ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("irsp check failed");

`endif

### rtl/irsp_pkg.sv
package irsp_pkg;

  localparam int MAX_TOOLTYPES    = 64;
  localparam int MAX_RECORD_BYTES = 4096;
  localparam int SEEN_W           = $clog2(MAX_RECORD_BYTES + 1);
  localparam int TTL_W            = $clog2(MAX_TOOLTYPES + 1);
  localparam int QDEPTH           = 4;
  localparam int QPTR_W           = $clog2(QDEPTH);
  localparam int QCNT_W           = $clog2(QDEPTH + 1);

  localparam logic [15:0] REC_MAGIC   = 16'hCA10;
  localparam logic [15:0] REC_VERSION = 16'h0001;
  localparam logic [7:0]  DRAWER_RST  = 8'd2;

  // event kinds
  localparam logic [4:0] EK_TYPE     = 5'd0;
  localparam logic [4:0] EK_X        = 5'd1;
  localparam logic [4:0] EK_Y        = 5'd2;
  localparam logic [4:0] EK_STACK    = 5'd3;
  localparam logic [4:0] EK_TOOL_LEN = 5'd4;
  localparam logic [4:0] EK_TOOL_BYT = 5'd5;
  localparam logic [4:0] EK_WIN_LEN  = 5'd6;
  localparam logic [4:0] EK_WIN_BYT  = 5'd7;
  localparam logic [4:0] EK_COUNT    = 5'd8;
  localparam logic [4:0] EK_TT_LEN   = 5'd9;
  localparam logic [4:0] EK_TT_BYT   = 5'd10;
  localparam logic [4:0] EK_LEFT     = 5'd11;
  localparam logic [4:0] EK_TOP      = 5'd12;
  localparam logic [4:0] EK_WIDTH    = 5'd13;
  localparam logic [4:0] EK_HEIGHT   = 5'd14;
  localparam logic [4:0] EK_DRAW_X   = 5'd15;
  localparam logic [4:0] EK_DRAW_Y   = 5'd16;
  localparam logic [4:0] EK_END      = 5'd17;

  // end status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_TOO_MANY  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  typedef enum logic [21:0] {
    PH_MAGIC   = 22'h000001,
    PH_VER     = 22'h000002,
    PH_TYPE    = 22'h000004,
    PH_FLAGS   = 22'h000008,
    PH_X       = 22'h000010,
    PH_Y       = 22'h000020,
    PH_STACK   = 22'h000040,
    PH_TLEN    = 22'h000080,
    PH_TBYTES  = 22'h000100,
    PH_WLEN    = 22'h000200,
    PH_WBYTES  = 22'h000400,
    PH_COUNT   = 22'h000800,
    PH_TTLEN   = 22'h001000,
    PH_TTBYTES = 22'h002000,
    PH_LE      = 22'h004000,
    PH_TE      = 22'h008000,
    PH_WI      = 22'h010000,
    PH_HE      = 22'h020000,
    PH_DDX     = 22'h040000,
    PH_DDY     = 22'h080000,
    PH_DONE    = 22'h100000,
    PH_ERR     = 22'h200000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  event_kind;
    logic [31:0] field_value;
    logic [5:0]  tooltype_index;
    logic [2:0]  status;
    logic        record_done;
  } out_evt_t;

  // one queue entry: the field event and/or the end event caused by a byte
  typedef struct packed {
    logic        fld_vld;
    logic [4:0]  kind;
    logic [31:0] value;
    logic [5:0]  idx;
    logic        end_vld;
    logic [2:0]  status;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] fld_width(phase_t ph);
    logic [2:0] w;
    case (ph)
      PH_MAGIC, PH_VER, PH_TLEN, PH_WLEN, PH_COUNT, PH_TTLEN,
      PH_LE, PH_TE, PH_WI, PH_HE:           w = 3'd2;
      PH_X, PH_Y, PH_STACK, PH_DDX, PH_DDY: w = 3'd4;
      default:                              w = 3'd1;
    endcase
    return w;
  endfunction

endpackage

### rtl/icon_record_stream_parser.sv
// Icon record stream parser.
// Input channel (in_valid / in_stall / in_data): one record byte per request,
// with last_byte set on the final byte of a record. A request is taken at a
// rising edge with in_valid high and in_stall low.
// Result channel (out_valid / out_stall / out_data): one event per request;
// the end event carries the status and record_done.
// Configuration: cfg_wr_en / cfg_wr_data write the drawer type code; write it
// only while the block is idle.
// Output path: the causing byte's events are written into the event queue and
// then loaded into the output register, where out_valid rises. Throughput:
// one byte per cycle while in_stall is low; a last byte that also completes a
// field yields two events, delivered one after the other. The front parser runs
// one byte a cycle when not stalled; a four-deep event queue decouples it from
// the output register, so in_stall rises only when that queue is full.
// Reset: synchronous, active low; the parser returns to expecting the magic,
// the queue and output empty, and the drawer code returns to 2.
// Receiver stall: the output register holds its event, the queue fills and
// then in_stall is raised until the receiver takes requests again.
module icon_record_stream_parser
  import irsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_req_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_evt_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic    push;
  logic    pop;
  logic    in_acc;
  qent_t   push_ent;
  qent_t   head;
  q_stat_t q_stat;

  // stall the source only when there is no room for another byte's events
  assign in_stall = q_stat.full;
  assign in_acc   = in_valid && !in_stall;

  // front: parse and classify each byte into field and end events
  irsp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .req         (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .push_ent    (push_ent)
  );

  // queue: decouple parsing from delivery
  irsp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // back: deliver the field event first, then the end event
  irsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/irsp_front.sv
module irsp_front
  import irsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  in_req_t    req,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output logic       push,
  output qent_t      push_ent
);

  phase_t             phase_r,  phase_nxt;
  logic [1:0]         pos_r,    pos_nxt;
  logic [31:0]        acc_r,    acc_nxt;
  logic [15:0]        sbl_r,    sbl_nxt;
  logic [TTL_W-1:0]   ttl_r,    ttl_nxt;
  logic [5:0]         ttn_r,    ttn_nxt;
  logic               drawer_r, drawer_nxt;
  logic [SEEN_W-1:0]  seen_r,   seen_nxt;
  logic [2:0]         err_r,    err_nxt;
  logic [7:0]         dcode_r,  dcode_nxt;

  always_comb begin
    logic [31:0]      v;
    logic [15:0]      sbl_dec;
    logic [TTL_W-1:0] ttl_dec;
    phase_t           ph_next_tt;
    phase_t           ph_after_tt;
    logic [7:0]       b;

    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    sbl_nxt    = sbl_r;
    ttl_nxt    = ttl_r;
    ttn_nxt    = ttn_r;
    drawer_nxt = drawer_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    dcode_nxt  = cfg_wr_en ? cfg_wr_data : dcode_r;
    push       = 1'b0;
    push_ent   = '0;

    b           = req.data_byte;
    v           = acc_r | ({24'd0, b} << {pos_r, 3'b000});
    sbl_dec     = (sbl_r != 16'd0) ? sbl_r - 16'd1 : 16'd0;
    ttl_dec     = (ttl_r != '0) ? ttl_r - 1'b1 : '0;
    ph_after_tt = drawer_r ? PH_LE : PH_DONE;
    ph_next_tt  = (ttl_dec == '0) ? ph_after_tt : PH_TTLEN;

    if (acc) begin
      if (seen_r >= SEEN_W'(MAX_RECORD_BYTES)) begin
        // overflow wins over any earlier error; drop the byte
        err_nxt   = ST_TOO_LONG;
        phase_nxt = PH_ERR;
      end else begin
        seen_nxt = seen_r + 1'b1;
        if (phase_r == PH_TBYTES || phase_r == PH_WBYTES || phase_r == PH_TTBYTES) begin
          push_ent.fld_vld = 1'b1;
          push_ent.value   = {24'd0, b};
          sbl_nxt          = sbl_dec;
          case (phase_r)
            PH_TBYTES: begin
              push_ent.kind = EK_TOOL_BYT;
              if (sbl_dec == 16'd0) phase_nxt = PH_WLEN;
            end
            PH_WBYTES: begin
              push_ent.kind = EK_WIN_BYT;
              if (sbl_dec == 16'd0) phase_nxt = PH_COUNT;
            end
            default: begin
              push_ent.kind = EK_TT_BYT;
              push_ent.idx  = ttn_r;
              if (sbl_dec == 16'd0) begin
                ttn_nxt   = ttn_r + 6'd1;
                ttl_nxt   = ttl_dec;
                phase_nxt = ph_next_tt;
              end
            end
          endcase
        end else if (phase_r != PH_DONE && phase_r != PH_ERR) begin
          if ({1'b0, pos_r} + 3'd1 < fld_width(phase_r)) begin
            acc_nxt = v;
            pos_nxt = pos_r + 2'd1;
          end else begin
            acc_nxt = '0;
            pos_nxt = '0;
            push_ent.value = v;
            case (phase_r)
              PH_MAGIC: begin
                if (v != {16'd0, REC_MAGIC}) begin
                  err_nxt = ST_BAD_MAGIC; phase_nxt = PH_ERR;
                end else phase_nxt = PH_VER;
              end
              PH_VER: begin
                if (v != {16'd0, REC_VERSION}) begin
                  err_nxt = ST_BAD_VER; phase_nxt = PH_ERR;
                end else phase_nxt = PH_TYPE;
              end
              PH_TYPE: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_TYPE;
                drawer_nxt = (v == {24'd0, dcode_r});
                phase_nxt  = PH_FLAGS;
              end
              PH_FLAGS: phase_nxt = PH_X;
              PH_X: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_X; phase_nxt = PH_Y;
              end
              PH_Y: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_Y; phase_nxt = PH_STACK;
              end
              PH_STACK: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_STACK; phase_nxt = PH_TLEN;
              end
              PH_TLEN: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_TOOL_LEN;
                sbl_nxt   = v[15:0];
                phase_nxt = (v != 32'd0) ? PH_TBYTES : PH_WLEN;
              end
              PH_WLEN: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_WIN_LEN;
                sbl_nxt   = v[15:0];
                phase_nxt = (v != 32'd0) ? PH_WBYTES : PH_COUNT;
              end
              PH_COUNT: begin
                if (v > 32'(MAX_TOOLTYPES)) begin
                  err_nxt = ST_TOO_MANY; phase_nxt = PH_ERR;
                end else begin
                  push_ent.fld_vld = 1'b1; push_ent.kind = EK_COUNT;
                  ttl_nxt   = v[TTL_W-1:0];
                  ttn_nxt   = '0;
                  phase_nxt = (v == 32'd0) ? ph_after_tt : PH_TTLEN;
                end
              end
              PH_TTLEN: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_TT_LEN;
                push_ent.idx = ttn_r;
                sbl_nxt = v[15:0];
                if (v != 32'd0) phase_nxt = PH_TTBYTES;
                else begin
                  ttn_nxt   = ttn_r + 6'd1;
                  ttl_nxt   = ttl_dec;
                  phase_nxt = ph_next_tt;
                end
              end
              PH_LE: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_LEFT; phase_nxt = PH_TE;
              end
              PH_TE: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_TOP; phase_nxt = PH_WI;
              end
              PH_WI: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_WIDTH; phase_nxt = PH_HE;
              end
              PH_HE: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_HEIGHT; phase_nxt = PH_DDX;
              end
              PH_DDX: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_DRAW_X; phase_nxt = PH_DDY;
              end
              PH_DDY: begin
                push_ent.fld_vld = 1'b1; push_ent.kind = EK_DRAW_Y; phase_nxt = PH_DONE;
              end
              default: ;
            endcase
          end
        end
      end

      if (req.last_byte) begin
        push_ent.end_vld = 1'b1;
        push_ent.status  = (err_nxt != ST_OK) ? err_nxt :
                           ((phase_nxt == PH_DONE) ? ST_OK : ST_TRUNC);
        phase_nxt  = PH_MAGIC;
        pos_nxt    = '0;
        acc_nxt    = '0;
        sbl_nxt    = '0;
        ttl_nxt    = '0;
        ttn_nxt    = '0;
        drawer_nxt = 1'b0;
        seen_nxt   = '0;
        err_nxt    = ST_OK;
      end
      push = push_ent.fld_vld | push_ent.end_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC;
      pos_r    <= '0;
      acc_r    <= '0;
      sbl_r    <= '0;
      ttl_r    <= '0;
      ttn_r    <= '0;
      drawer_r <= 1'b0;
      seen_r   <= '0;
      err_r    <= ST_OK;
      dcode_r  <= DRAWER_RST;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      sbl_r    <= sbl_nxt;
      ttl_r    <= ttl_nxt;
      ttn_r    <= ttn_nxt;
      drawer_r <= drawer_nxt;
      seen_r   <= seen_nxt;
      err_r    <= err_nxt;
      dcode_r  <= dcode_nxt;
    end
  end

endmodule

### rtl/irsp_queue.sv
module irsp_queue
  import irsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qent_t   push_ent,
  input  logic    pop,
  output qent_t   head,
  output q_stat_t stat
);

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r,    cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/irsp_back.sv
module irsp_back
  import irsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  qent_t    head,
  input  q_stat_t  stat,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output out_evt_t out_data
);

  logic     out_valid_r, out_valid_nxt;
  out_evt_t out_r,       out_nxt;
  logic     half_r,      half_nxt;
  logic     slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    half_nxt      = half_r;
    pop           = 1'b0;
    if (slot_free) begin
      out_valid_nxt = 1'b0;
      if (!stat.empty) begin
        out_valid_nxt = 1'b1;
        if (head.fld_vld && !half_r) begin
          out_nxt.event_kind     = head.kind;
          out_nxt.field_value    = head.value;
          out_nxt.tooltype_index = head.idx;
          out_nxt.status         = ST_OK;
          out_nxt.record_done    = 1'b0;
          // hold the entry if its end event still has to follow
          half_nxt = head.end_vld;
          pop      = !head.end_vld;
        end else begin
          out_nxt.event_kind     = EK_END;
          out_nxt.field_value    = '0;
          out_nxt.tooltype_index = '0;
          out_nxt.status         = head.status;
          out_nxt.record_done    = 1'b1;
          half_nxt = 1'b0;
          pop      = 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
  end

endmodule

### rtl/irsp_checker.sv
`include "icon_record_stream_parser_defines.svh"

module irsp_checker
  import irsp_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input in_req_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input out_evt_t out_data
);

  logic is_end;
  logic end_ok;

  assign is_end = out_valid && (out_data.record_done || out_data.event_kind == EK_END);
  assign end_ok = out_data.record_done && out_data.event_kind == EK_END &&
                  out_data.field_value == 32'd0 && out_data.tooltype_index == 6'd0;

  `IRSP_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))
  `IRSP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `IRSP_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `IRSP_ASSERT_NXT_RST(a_reset_idle, !rst_n, !out_valid && !in_stall)
  `IRSP_ASSERT_IMP(a_end_shape, is_end, end_ok)

endmodule

bind icon_record_stream_parser irsp_checker u_chk (.*);
